[sv/ucc_pkg.sv]
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared types and constants for the Unix time to CET calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ucc_pkg;

	// register stages inside the date conversion pipeline
	localparam int CONV_LAT = 7;

	localparam logic [31:0] ZONE_OFFSET   = 32'd3600;
	localparam logic [31:0] SUMMER_OFFSET = 32'd7200;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_t;

endpackage

`default_nettype wire

[sv/ucc_ifs.sv]
// ----------------------------------------------------------------------------
// ucc_ifs
// Valid/ready channels: timestamp in, local calendar fields out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucc_ts_if;
	logic        valid;
	logic        ready;
	logic [30:0] unix_seconds;
	logic        force_summer;

	modport source (output valid, unix_seconds, force_summer, input ready);
	modport sink (input valid, unix_seconds, force_summer, output ready);
endinterface

interface ucc_cal_if;
	logic        valid;
	logic        ready;
	logic [10:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        summer_time;

	modport source (output valid, year, month, day, hour, minute, second, summer_time,
		input ready);
	modport sink (input valid, year, month, day, hour, minute, second, summer_time,
		output ready);
endinterface

`default_nettype wire

[sv/unix_time_to_cet_calendar_top.sv]
// ----------------------------------------------------------------------------
// unix_time_to_cet_calendar_top
// Unix seconds to central European local date and time with summer rules.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  ts       in   valid/ready   unix_seconds[30:0], force_summer
//  cal      out  valid/ready   year, month, day, hour, minute, second, summer_time
//
//  Registered path: input register, 7 conversion stages, output register.
//  One transaction per cycle unless stalled; winter and summer conversions run in parallel
//  and the output stage applies the summer rules to the winter result.
//  The whole pipeline holds while the output register is full and not taken.
//  arst_n clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_cet_calendar_top (
	input  wire logic clk,
	input  wire logic arst_n,
	ucc_ts_if.sink    ts,
	ucc_cal_if.source cal
);
	import ucc_pkg::*;

	logic en;
	logic out_vld_q;

	assign en       = !out_vld_q || cal.ready;
	assign ts.ready = en;

	// input stage: both local offsets
	logic [31:0] sec_w_s1;
	logic [31:0] sec_s_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sec_w_s1 <= {1'b0, ts.unix_seconds} + ZONE_OFFSET;
			sec_s_s1 <= {1'b0, ts.unix_seconds} + SUMMER_OFFSET;
		end
	end

	// valid and force flag travel alongside the conversions
	logic vld_q   [0:CONV_LAT];
	logic force_q [0:CONV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CONV_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= ts.valid;
			for (int i = 1; i <= CONV_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_q[0] <= ts.force_summer;
			for (int i = 1; i <= CONV_LAT; i++) force_q[i] <= force_q[i-1];
		end
	end

	cal_t       win_cal;
	cal_t       sum_cal;
	logic [2:0] win_wday;

	ucc_conv u_conv_win (
		.clk     (clk),
		.en      (en),
		.secs    (sec_w_s1),
		.cal     (win_cal),
		.weekday (win_wday)
	);

	ucc_conv u_conv_sum (
		.clk     (clk),
		.en      (en),
		.secs    (sec_s_s1),
		.cal     (sum_cal),
		.weekday ()
	);

	// summer rules on the winter fields
	logic [5:0] k;
	logic       w_sun;
	logic       rule_hit;
	logic       summer;

	always_comb begin
		k        = 6'd32 - {1'b0, win_cal.day} + {3'd0, win_wday};
		w_sun    = (win_wday == 3'd0);
		rule_hit = 1'b0;
		if (win_cal.month >= 4'd4 && win_cal.month <= 4'd9)
			rule_hit = 1'b1;
		if (win_cal.month == 4'd3 && k < 6'd7 && !w_sun)
			rule_hit = 1'b1;
		if (win_cal.month == 4'd3 && k < 6'd7 && w_sun && win_cal.hour > 5'd1)
			rule_hit = 1'b1;
		if (win_cal.month == 4'd10 && k > 6'd7)
			rule_hit = 1'b1;
		if (win_cal.month == 4'd10 && k < 6'd7 && w_sun && win_cal.hour < 5'd2)
			rule_hit = 1'b1;
		summer = force_q[CONV_LAT] || rule_hit;
	end

	// output register
	cal_t out_q;
	logic summer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_q[CONV_LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q    <= summer ? sum_cal : win_cal;
			summer_q <= summer;
		end
	end

	assign cal.valid       = out_vld_q;
	assign cal.year        = out_q.year;
	assign cal.month       = out_q.month;
	assign cal.day         = out_q.day;
	assign cal.hour        = out_q.hour;
	assign cal.minute      = out_q.minute;
	assign cal.second      = out_q.second;
	assign cal.summer_time = summer_q;

endmodule

`default_nettype wire

[sv/ucc_conv.sv]
// ----------------------------------------------------------------------------
// ucc_conv
// Seven-stage seconds-to-calendar pipeline (Gregorian, 1970..2057 window),
// plus the weekday of the UTC day for a one-hour zone offset.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_conv (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] secs,
	output ucc_pkg::cal_t    cal,
	output logic [2:0]       weekday
);
	import ucc_pkg::*;

	// day offset of each month, counted from March 1
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// stage 1: days = secs / 86400 as (secs >> 7) / 675 by reciprocal
	logic [50:0] days_prod;
	logic [14:0] days_s1;
	logic [16:0] secs_lo_s1;

	assign days_prod = 51'(secs[31:7]) * 51'd50903317;

	always_ff @(posedge clk) begin
		if (en) begin
			days_s1    <= days_prod[49:35];
			secs_lo_s1 <= secs[16:0];
		end
	end

	// stage 2: seconds of day, days since 1968-03-01
	logic [31:0] day_secs;
	logic [16:0] rem_s2;
	logic [14:0] dd_s2;
	logic [14:0] days_s2;

	assign day_secs = 32'(days_s1) * 32'd86400;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= secs_lo_s1 - day_secs[16:0];
			dd_s2   <= days_s1 + 15'd671;
			days_s2 <= days_s1;
		end
	end

	// stage 3: hour = rem / 3600, four-year cycle = dd / 1461
	logic [26:0] hour_prod;
	logic [30:0] cyc_prod;
	logic [4:0]  hour_s3;
	logic [4:0]  cyc_s3;
	logic [16:0] rem_s3;
	logic [14:0] dd_s3;
	logic [14:0] days_s3;

	assign hour_prod = 27'(rem_s2[16:4]) * 27'd9321;
	assign cyc_prod  = 31'(dd_s2) * 31'd45934;

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s3 <= hour_prod[25:21];
			cyc_s3  <= cyc_prod[30:26];
			rem_s3  <= rem_s2;
			dd_s3   <= dd_s2;
			days_s3 <= days_s2;
		end
	end

	// stage 4: seconds of hour, day within cycle, UTC day index + 4
	logic [16:0] hour_secs;
	logic [15:0] cyc_days;
	logic [11:0] r2_s4;
	logic [10:0] r_s4;
	logic [14:0] wx_s4;
	logic [4:0]  hour_s4;
	logic [4:0]  cyc_s4;

	assign hour_secs = 17'(hour_s3) * 17'd3600;
	assign cyc_days  = 16'(cyc_s3) * 16'd1461;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s4   <= rem_s3[11:0] - hour_secs[11:0];
			r_s4    <= dd_s3[10:0] - cyc_days[10:0];
			// local midnight hour belongs to the previous UTC day
			wx_s4   <= days_s3 - 15'(hour_s3 == 5'd0) + 15'd4;
			hour_s4 <= hour_s3;
			cyc_s4  <= cyc_s3;
		end
	end

	// stage 5: minute, year of cycle and day of year, weekday quotient
	logic [20:0] min_prod;
	logic [30:0] wq_prod;
	logic [1:0]  yoe;
	logic [10:0] yoe_days;
	logic [5:0]  minute_s5;
	logic [1:0]  yoe_s5;
	logic [8:0]  doy_s5;
	logic [11:0] wq_s5;
	logic [2:0]  wx_s5;
	logic [11:0] r2_s5;
	logic [4:0]  hour_s5;
	logic [4:0]  cyc_s5;

	assign min_prod = 21'(r2_s4[11:2]) * 21'd1093;
	assign wq_prod  = 31'(wx_s4) * 31'd37450;

	always_comb begin
		// leap day of the cycle stays in the last year
		if (r_s4 >= 11'd1095) begin
			yoe      = 2'd3;
			yoe_days = 11'd1095;
		end else if (r_s4 >= 11'd730) begin
			yoe      = 2'd2;
			yoe_days = 11'd730;
		end else if (r_s4 >= 11'd365) begin
			yoe      = 2'd1;
			yoe_days = 11'd365;
		end else begin
			yoe      = 2'd0;
			yoe_days = 11'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			minute_s5 <= min_prod[19:14];
			yoe_s5    <= yoe;
			doy_s5    <= 9'(r_s4 - yoe_days);
			wq_s5     <= wq_prod[29:18];
			wx_s5     <= wx_s4[2:0];
			r2_s5     <= r2_s4;
			hour_s5   <= hour_s4;
			cyc_s5    <= cyc_s4;
		end
	end

	// stage 6: second, month from March, weekday
	logic [22:0] mp_prod;
	logic [11:0] min_secs;
	logic [14:0] wq7;
	logic [5:0]  second_s6;
	logic [3:0]  mp_s6;
	logic [2:0]  w_s6;
	logic [8:0]  doy_s6;
	logic [5:0]  minute_s6;
	logic [4:0]  hour_s6;
	logic [4:0]  cyc_s6;
	logic [1:0]  yoe_s6;

	assign mp_prod  = 23'(11'(doy_s5) * 11'd5 + 11'd2) * 23'd3427;
	assign min_secs = 12'(minute_s5) * 12'd60;
	assign wq7      = 15'(wq_s5) * 15'd7;

	always_ff @(posedge clk) begin
		if (en) begin
			second_s6 <= r2_s5[5:0] - min_secs[5:0];
			mp_s6     <= mp_prod[22:19];
			w_s6      <= wx_s5 - wq7[2:0];
			doy_s6    <= doy_s5;
			minute_s6 <= minute_s5;
			hour_s6   <= hour_s5;
			cyc_s6    <= cyc_s5;
			yoe_s6    <= yoe_s5;
		end
	end

	// stage 7: day, civil month and year
	logic [3:0]  month_c;
	logic [10:0] year_c;
	cal_t        cal_s7;
	logic [2:0]  w_s7;

	always_comb begin
		month_c = (mp_s6 < 4'd10) ? mp_s6 + 4'd3 : mp_s6 - 4'd9;
		year_c  = 11'd1968 + {4'd0, cyc_s6, 2'd0} + 11'(yoe_s6)
			+ 11'(month_c <= 4'd2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cal_s7.year   <= year_c;
			cal_s7.month  <= month_c;
			cal_s7.day    <= 5'(doy_s6 - month_start(mp_s6) + 9'd1);
			cal_s7.hour   <= hour_s6;
			cal_s7.minute <= minute_s6;
			cal_s7.second <= second_s6;
			w_s7          <= w_s6;
		end
	end

	assign cal     = cal_s7;
	assign weekday = w_s7;

endmodule

`default_nettype wire

[sv/ucc_checker.sv]
// ----------------------------------------------------------------------------
// ucc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        ts_ready,
	input wire logic        cal_valid,
	input wire logic        cal_ready,
	input wire logic [3:0]  cal_month,
	input wire logic [4:0]  cal_day,
	input wire logic [4:0]  cal_hour,
	input wire logic [5:0]  cal_minute,
	input wire logic [5:0]  cal_second,
	input wire logic        cal_summer_time
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && !cal_ready |=> cal_valid && $stable(cal_month) && $stable(cal_day)
			&& $stable(cal_hour) && $stable(cal_minute) && $stable(cal_second))
		else $error("result changed while stalled");

	// fields stay in calendar range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1
			&& cal_hour <= 5'd23 && cal_minute <= 6'd59 && cal_second <= 6'd59)
		else $error("calendar field out of range");

	// April through September is always summer time
	a_summer: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && cal_month >= 4'd4 && cal_month <= 4'd9 |-> cal_summer_time)
		else $error("summer month without summer offset");

	// a full, stalled output register blocks the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && !cal_ready |-> !ts_ready)
		else $error("input taken while output stalled");

endmodule

bind unix_time_to_cet_calendar_top ucc_checker u_ucc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.ts_ready        (ts.ready),
	.cal_valid       (cal.valid),
	.cal_ready       (cal.ready),
	.cal_month       (cal.month),
	.cal_day         (cal.day),
	.cal_hour        (cal.hour),
	.cal_minute      (cal.minute),
	.cal_second      (cal.second),
	.cal_summer_time (cal.summer_time)
);

`default_nettype wire
